[design/chip8_interpreter_core_assert.svh]
// ----------------------------------------------------------------------------
// chip8_interpreter_core_assert.svh
// Assertion macros for the CHIP-8 core.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INTERPRETER_CORE_ASSERT_SVH
`define CHIP8_INTERPRETER_CORE_ASSERT_SVH
`ifndef SYNTH
`define CHIP8_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("chip8 core assertion failed");
`define CHIP8_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("chip8 core reset assertion failed");
`else
`define CHIP8_ASSERT(lbl, prop)
`define CHIP8_ASSERT_RST(lbl, prop)
`endif
`endif

[design/chip8_pkg.sv]
// ----------------------------------------------------------------------------
// chip8_pkg
// Sequencer states, word kinds, opcodes and the font for the CHIP-8 core.
// ----------------------------------------------------------------------------
package chip8_pkg;

  localparam int MEM_AW = 12;
  localparam int SCR_AW = 5;
  localparam int SCR_W  = 64;

  localparam logic [2:0] KIND_RESET = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_START = 3'd2;
  localparam logic [2:0] KIND_EXEC  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;
  localparam logic [2:0] KIND_KEY   = 3'd5;
  localparam logic [2:0] KIND_ROW   = 3'd6;

  localparam logic [15:0] PROG_BASE = 16'h0200;
  localparam logic [15:0] FONT_BASE = 16'h0050;
  localparam logic [15:0] OP_CLS    = 16'h00E0;
  localparam logic [15:0] OP_RET    = 16'h00EE;
  localparam logic [15:0] PC_LIMIT  = 16'h0FFF;

  localparam logic [7:0] FN_LD_DT  = 8'h07;
  localparam logic [7:0] FN_WAIT   = 8'h0A;
  localparam logic [7:0] FN_SET_DT = 8'h15;
  localparam logic [7:0] FN_SET_ST = 8'h18;
  localparam logic [7:0] FN_ADD_I  = 8'h1E;
  localparam logic [7:0] FN_FONT   = 8'h29;
  localparam logic [7:0] FN_BCD    = 8'h33;
  localparam logic [7:0] FN_STORE  = 8'h55;
  localparam logic [7:0] FN_LOAD   = 8'h65;
  localparam logic [7:0] FN_SKP    = 8'h9E;
  localparam logic [7:0] FN_SKNP   = 8'hA1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_OPER, S_EXEC, S_CLS,
    S_DRAW_RD, S_DRAW_WR, S_BCD, S_STORE, S_LOAD_RD, S_LOAD_WR, S_ROW, S_DONE
  } state_t;

  localparam logic [7:0] GLYPHS [80] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] addr);
    logic [MEM_AW-1:0] off;
    off = addr - FONT_BASE[MEM_AW-1:0];
    if (addr >= FONT_BASE[MEM_AW-1:0] && addr < MEM_AW'(12'h0A0)) begin
      return GLYPHS[off[6:0]];
    end
    return 8'h00;
  endfunction

endpackage

[design/chip8_ram.sv]
// ----------------------------------------------------------------------------
// chip8_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module chip8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/chip8_interpreter_core.sv]
// ----------------------------------------------------------------------------
// chip8_interpreter_core
// CHIP-8 machine core: memory and screen in RAMs, one word per operation.
//
//   channel | handshake           | payload
//   in      | in_valid / in_ready | kind, load_address, load_data, key_number,
//           |                     | key_down, row_select, random_byte
//   out     | out_valid/out_ready | program_counter, is_running, awaiting_key,
//           |                     | redraw_needed, sound_on, row_pixels
//
// Row reads and executes pass through more states than other words; execute
// adds states for clear screen, each sprite row, BCD digits and each register
// in block moves.
// Reset and a reset word sweep main memory with in_ready low.
// A finished word waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
module chip8_interpreter_core
  import chip8_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [11:0] load_address,
  input  logic [7:0]  load_data,
  input  logic [3:0]  key_number,
  input  logic        key_down,
  input  logic [4:0]  row_select,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] program_counter,
  output logic        is_running,
  output logic        awaiting_key,
  output logic        redraw_needed,
  output logic        sound_on,
  output logic [63:0] row_pixels
);

`include "chip8_interpreter_core_assert.svh"

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SI_W = $clog2(STACK_DEPTH);

  state_t state, state_next;

  logic [15:0]       pc, ir;
  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_dec;
  logic [7:0]        dt, st;
  logic              dp, kwait, run;
  logic [3:0]        ktarget;
  logic [15:0]       keys;
  logic [7:0]        v [16];
  logic [15:0]       stack [STACK_DEPTH];
  logic [7:0]        op_hi, op_lo, va, vb, rnd;
  logic [11:0]       cnt;
  logic              hit, reply, snap;
  logic [2:0]        k_item;
  logic [63:0]       row_buf;

  logic              accept;
  logic [15:0]       op, pc_skip;
  logic [3:0]        x, y, n;
  logic [11:0]       nnn;
  logic [3:0]        v_ridx;
  logic [7:0]        v_rd;
  logic [3:0]        key_idx;
  logic              key_any;
  logic              key_hit;
  logic [4:0]        draw_row;
  logic [63:0]       sprite;
  logic              draw_last, move_last;
  logic [16:0]       addr_sum;
  logic [8:0]        sum9;
  logic [1:0]        bcd_h;
  logic [7:0]        bcd_rem;
  logic [14:0]       bcd_prod;
  logic [3:0]        bcd_t;
  logic [7:0]        bcd_o;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              scr_we;
  logic [SCR_AW-1:0] scr_waddr, scr_raddr;
  logic [SCR_W-1:0]  scr_wdata, scr_rdata;

  chip8_ram #(.WIDTH(8), .DEPTH(4096)) u_main_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  chip8_ram #(.WIDTH(SCR_W), .DEPTH(32)) u_screen_mem (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign op       = {op_hi, op_lo};
  assign x        = op_hi[3:0];
  assign y        = op_lo[7:4];
  assign n        = op_lo[3:0];
  assign nnn      = {op_hi[3:0], op_lo};
  assign pc_skip  = pc + 16'd2;
  assign v_rd     = v[v_ridx];
  assign sp_dec   = sp - SP_W'(1);
  assign key_hit  = (va < 8'd16) && keys[va[3:0]];
  assign sum9     = {1'b0, va} + {1'b0, vb};

  assign draw_row  = vb[4:0] + cnt[4:0];
  assign sprite    = {mem_rdata, 56'b0} >> va[5:0];
  assign draw_last = ({1'b0, cnt[3:0]} + 5'd1 == {1'b0, n}) || (draw_row == 5'd31);
  assign addr_sum  = {1'b0, ir} + {13'b0, cnt[3:0]};
  assign move_last = (cnt[3:0] == x) || (addr_sum >= 17'h00FFF);

  assign bcd_h    = (va >= 8'd200) ? 2'd2 : (va >= 8'd100) ? 2'd1 : 2'd0;
  assign bcd_rem  = va - ({6'b0, bcd_h} * 8'd100);
  assign bcd_prod = 15'(bcd_rem) * 15'd205;
  assign bcd_t    = bcd_prod[14:11];
  assign bcd_o    = bcd_rem - ({4'b0, bcd_t} * 8'd10);

  always_comb begin
    key_idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys[i]) begin
        key_idx = 4'(i);
      end
    end
    key_any = |keys;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = load_address;
    mem_wdata  = load_data;
    mem_raddr  = pc[MEM_AW-1:0];
    scr_we     = 1'b0;
    scr_waddr  = draw_row;
    scr_wdata  = scr_rdata ^ sprite;
    scr_raddr  = row_select;
    v_ridx     = x;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = font_byte(cnt);
        scr_we    = 1'b1;
        scr_waddr = cnt[SCR_AW-1:0];
        scr_wdata = '0;
        if (cnt == 12'hFFF) begin
          state_next = reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_RESET: state_next = S_CLEAR;
            KIND_LOAD: begin
              mem_we     = 1'b1;
              state_next = S_DONE;
            end
            KIND_EXEC: begin
              state_next = (run && !kwait && pc < PC_LIMIT) ? S_FETCH_HI : S_DONE;
            end
            KIND_ROW: state_next = S_ROW;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_FETCH_HI: state_next = S_FETCH_LO;
      S_FETCH_LO: begin
        mem_raddr  = pc[MEM_AW-1:0] + 12'd1;
        state_next = S_DECODE;
      end
      S_DECODE: state_next = S_OPER;
      S_OPER: begin
        v_ridx     = y;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (op_hi[7:4])
          4'h0: begin
            if (op == OP_CLS) begin
              state_next = S_CLS;
            end
          end
          4'hD: begin
            if (n != 4'd0) begin
              state_next = S_DRAW_RD;
            end
          end
          4'hF: begin
            case (op_lo)
              FN_BCD: begin
                if (ir < 16'h0FFE) begin
                  state_next = S_BCD;
                end
              end
              FN_STORE: begin
                if (ir < 16'h1000) begin
                  state_next = S_STORE;
                end
              end
              FN_LOAD: begin
                if (ir < 16'h1000) begin
                  state_next = S_LOAD_RD;
                end
              end
              default: state_next = S_DONE;
            endcase
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CLS: begin
        scr_we    = 1'b1;
        scr_waddr = cnt[SCR_AW-1:0];
        scr_wdata = '0;
        if (cnt[4:0] == 5'd31) begin
          state_next = S_DONE;
        end
      end
      S_DRAW_RD: begin
        mem_raddr  = ir[MEM_AW-1:0] + {8'b0, cnt[3:0]};
        scr_raddr  = draw_row;
        state_next = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        scr_we     = 1'b1;
        state_next = draw_last ? S_DONE : S_DRAW_RD;
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = ir[MEM_AW-1:0] + {10'b0, cnt[1:0]};
        case (cnt[1:0])
          2'd0:    mem_wdata = {6'b0, bcd_h};
          2'd1:    mem_wdata = {4'b0, bcd_t};
          default: mem_wdata = bcd_o;
        endcase
        if (cnt[1:0] == 2'd2) begin
          state_next = S_DONE;
        end
      end
      S_STORE: begin
        v_ridx     = cnt[3:0];
        mem_we     = 1'b1;
        mem_waddr  = ir[MEM_AW-1:0] + {8'b0, cnt[3:0]};
        mem_wdata  = v_rd;
        state_next = move_last ? S_DONE : S_STORE;
      end
      S_LOAD_RD: begin
        mem_raddr  = ir[MEM_AW-1:0] + {8'b0, cnt[3:0]};
        state_next = S_LOAD_WR;
      end
      S_LOAD_WR: state_next = move_last ? S_DONE : S_LOAD_RD;
      S_ROW:     state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PROG_BASE;
      ir        <= '0;
      sp        <= '0;
      dt        <= '0;
      st        <= '0;
      dp        <= 1'b1;
      kwait     <= 1'b0;
      ktarget   <= '0;
      run       <= 1'b0;
      keys      <= '0;
      cnt       <= '0;
      reply     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        v[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: cnt <= cnt + 12'd1;
        S_IDLE: begin
          if (accept) begin
            k_item  <= kind;
            rnd     <= random_byte;
            row_buf <= '0;
            snap    <= dp;
            cnt     <= '0;
            case (kind)
              KIND_RESET: begin
                pc      <= PROG_BASE;
                ir      <= '0;
                sp      <= '0;
                dt      <= '0;
                st      <= '0;
                dp      <= 1'b1;
                kwait   <= 1'b0;
                ktarget <= '0;
                run     <= 1'b0;
                keys    <= '0;
                reply   <= 1'b1;
                for (int i = 0; i < 16; i++) begin
                  v[i] <= '0;
                end
              end
              KIND_START: run <= 1'b1;
              KIND_EXEC: begin
                if (run) begin
                  if (kwait) begin
                    if (key_any) begin
                      v[ktarget] <= {4'b0, key_idx};
                      kwait      <= 1'b0;
                    end
                  end else if (pc >= PC_LIMIT) begin
                    run <= 1'b0;
                  end
                end
              end
              KIND_TICK: begin
                if (dt != 8'd0) begin
                  dt <= dt - 8'd1;
                end
                if (st != 8'd0) begin
                  st <= st - 8'd1;
                end
                dp <= 1'b0;
              end
              KIND_KEY: keys[key_number] <= key_down;
              default: ;
            endcase
          end
        end
        S_FETCH_LO: op_hi <= mem_rdata;
        S_DECODE: begin
          op_lo <= mem_rdata;
          va    <= v_rd;
          pc    <= pc_skip;
        end
        S_OPER: vb <= v_rd;
        S_EXEC: begin
          cnt <= '0;
          hit <= 1'b0;
          case (op_hi[7:4])
            4'h0: begin
              if (op == OP_CLS) begin
                dp <= 1'b1;
              end else if (op == OP_RET && sp != '0) begin
                sp <= sp_dec;
                pc <= stack[sp_dec[SI_W-1:0]];
              end
            end
            4'h1: pc <= {4'b0, nnn};
            4'h2: begin
              if (sp < SP_W'(STACK_DEPTH)) begin
                stack[sp[SI_W-1:0]] <= pc;
                sp <= sp + SP_W'(1);
              end
              pc <= {4'b0, nnn};
            end
            4'h3: if (va == op_lo) pc <= pc_skip;
            4'h4: if (va != op_lo) pc <= pc_skip;
            4'h5: if (va == vb) pc <= pc_skip;
            4'h6: v[x] <= op_lo;
            4'h7: v[x] <= va + op_lo;
            4'h8: begin
              case (n)
                4'h0: v[x] <= vb;
                4'h1: begin
                  v[x]  <= va | vb;
                  v[15] <= 8'd0;
                end
                4'h2: begin
                  v[x]  <= va & vb;
                  v[15] <= 8'd0;
                end
                4'h3: begin
                  v[x]  <= va ^ vb;
                  v[15] <= 8'd0;
                end
                4'h4: begin
                  v[x]  <= sum9[7:0];
                  v[15] <= {7'b0, sum9[8]};
                end
                4'h5: begin
                  v[x]  <= va - vb;
                  v[15] <= {7'b0, va >= vb};
                end
                4'h6: begin
                  v[x]  <= va >> 1;
                  v[15] <= {7'b0, va[0]};
                end
                4'h7: begin
                  v[x]  <= vb - va;
                  v[15] <= {7'b0, vb >= va};
                end
                4'hE: begin
                  v[x]  <= va << 1;
                  v[15] <= {7'b0, va[7]};
                end
                default: ;
              endcase
            end
            4'h9: if (va != vb) pc <= pc_skip;
            4'hA: ir <= {4'b0, nnn};
            4'hB: pc <= {4'b0, nnn} + {8'b0, v[0]};
            4'hC: v[x] <= rnd & op_lo;
            4'hD: begin
              if (n == 4'd0) begin
                v[15] <= 8'd0;
                dp    <= 1'b1;
              end
            end
            4'hE: begin
              if (op_lo == FN_SKP && key_hit) begin
                pc <= pc_skip;
              end else if (op_lo == FN_SKNP && !key_hit) begin
                pc <= pc_skip;
              end
            end
            default: begin
              case (op_lo)
                FN_LD_DT:  v[x] <= dt;
                FN_WAIT: begin
                  kwait   <= 1'b1;
                  ktarget <= x;
                end
                FN_SET_DT: dt <= va;
                FN_SET_ST: st <= va;
                FN_ADD_I:  ir <= ir + {8'b0, va};
                FN_FONT:   ir <= FONT_BASE + {10'b0, va[3:0], 2'b0} + {12'b0, va[3:0]};
                default: ;
              endcase
            end
          endcase
        end
        S_CLS: cnt <= cnt + 12'd1;
        S_DRAW_WR: begin
          cnt <= cnt + 12'd1;
          if ((scr_rdata & sprite) != '0) begin
            hit <= 1'b1;
          end
          if (draw_last) begin
            v[15] <= {7'b0, hit | ((scr_rdata & sprite) != '0)};
            dp    <= 1'b1;
          end
        end
        S_BCD:   cnt <= cnt + 12'd1;
        S_STORE: cnt <= cnt + 12'd1;
        S_LOAD_WR: begin
          v[cnt[3:0]] <= mem_rdata;
          cnt         <= cnt + 12'd1;
        end
        S_ROW: row_buf <= scr_rdata;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            program_counter <= pc;
            is_running      <= run;
            awaiting_key    <= kwait;
            redraw_needed   <= (k_item == KIND_TICK) ? snap : dp;
            sound_on        <= (st != 8'd0);
            row_pixels      <= row_buf;
            reply           <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `CHIP8_ASSERT_RST(a_sweep_after_rst, rst |=> !in_ready)
  `CHIP8_ASSERT(a_stack_bound, sp <= SP_W'(STACK_DEPTH))
  `CHIP8_ASSERT(a_wait_needs_run, kwait |-> run)

endmodule

[tb/chip8_interpreter_core_test.sv]
// ----------------------------------------------------------------------------
// chip8_interpreter_core_test
// Self-checking bench for the CHIP-8 core. An initial block queues words:
// a directed opening, then short random programs that are loaded, started
// and stepped, mixed with ticks, keys, row reads and noise. A clocked driver
// offers the words with random gaps. A clocked monitor checks every result
// against a machine model that the bench steps on each accepted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chip8_interpreter_core_test
  import chip8_pkg::*;
;

  localparam int ITEM_GOAL   = 1450;
  localparam int CALM_AFTER  = 1300;
  localparam int WDOG_LIMIT  = 30000;
  localparam int STACK_SLOTS = 16;

  typedef enum logic [3:0] {
    OPC_SYS, OPC_JP, OPC_CALL, OPC_SE, OPC_SNE, OPC_SER, OPC_LD, OPC_ADD,
    OPC_ALU, OPC_SNER, OPC_LDI, OPC_JPV, OPC_RND, OPC_DRW, OPC_KEY, OPC_MISC
  } opclass_t;

  typedef enum logic [3:0] {
    ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3, ALU_ADD = 4'h4,
    ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7, ALU_SHL = 4'hE
  } alu_t;

  typedef struct {
    bit          drain;
    logic [2:0]  kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [3:0]  key;
    logic        down;
    logic [4:0]  row;
    logic [7:0]  rnd;
  } word_t;

  typedef struct {
    logic [15:0] pc;
    logic        run;
    logic        wait_k;
    logic        redraw;
    logic        sound;
    logic [63:0] pixels;
  } status_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] kind;
  logic [11:0] load_address;
  logic [7:0] load_data, random_byte;
  logic [3:0] key_number;
  logic key_down;
  logic [4:0] row_select;
  logic [15:0] program_counter;
  logic is_running, awaiting_key, redraw_needed, sound_on;
  logic [63:0] row_pixels;

  chip8_interpreter_core DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .load_address(load_address), .load_data(load_data), .key_number(key_number),
    .key_down(key_down), .row_select(row_select), .random_byte(random_byte),
    .out_valid(out_valid), .out_ready(out_ready), .program_counter(program_counter),
    .is_running(is_running), .awaiting_key(awaiting_key),
    .redraw_needed(redraw_needed), .sound_on(sound_on), .row_pixels(row_pixels)
  );

  // machine model
  logic [7:0]  mem [4096];
  logic [7:0]  vreg [16];
  logic [15:0] idx_reg, pc_reg;
  logic [15:0] ret_stack [STACK_SLOTS];
  int          sp;
  logic [7:0]  delay_cnt, sound_cnt;
  logic [63:0] screen [32];
  logic        keys [16];
  logic        redraw_flag, key_waiting, running;
  logic [3:0]  key_dest;

  word_t   pending_words [$];
  status_t expected_status [$];
  int  words_taken, results_seen, fail_count, idle_cycles;
  bit  in_taken, draining, stim_done;
  int  in_gap, out_gap;

  function automatic void machine_reset();
    for (int i = 0; i < 4096; i++) mem[i] = 8'h00;
    for (int i = 0; i < 80; i++) mem[FONT_BASE + i] = GLYPHS[i];
    for (int i = 0; i < 16; i++) begin
      vreg[i] = 8'h00;
      ret_stack[i] = 16'h0000;
      keys[i] = 1'b0;
    end
    for (int i = 0; i < 32; i++) screen[i] = 64'h0;
    idx_reg = 16'h0;
    pc_reg = PROG_BASE;
    sp = 0;
    delay_cnt = 8'h0;
    sound_cnt = 8'h0;
    redraw_flag = 1'b1;
    key_waiting = 1'b0;
    key_dest = 4'h0;
    running = 1'b0;
  endfunction

  function automatic void machine_execute(input logic [7:0] rnd);
    logic [15:0] op;
    logic [3:0] x, y, n;
    logic [7:0] nn, f;
    logic [11:0] nnn;
    logic [8:0] sum;
    logic [63:0] bits;
    int xpos, ypos;
    logic hit;
    if (!running) return;
    if (key_waiting) begin
      for (int i = 0; i < 16; i++) begin
        if (keys[i]) begin
          vreg[key_dest] = 8'(i);
          key_waiting = 1'b0;
          break;
        end
      end
      return;
    end
    if (pc_reg >= PC_LIMIT) begin
      running = 1'b0;
      return;
    end
    op = {mem[pc_reg[11:0]], mem[pc_reg[11:0] + 12'd1]};
    pc_reg = pc_reg + 16'd2;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    nnn = op[11:0];
    case (opclass_t'(op[15:12]))
      OPC_SYS: begin
        if (op == OP_CLS) begin
          for (int i = 0; i < 32; i++) screen[i] = 64'h0;
          redraw_flag = 1'b1;
        end else if (op == OP_RET && sp > 0) begin
          sp--;
          pc_reg = ret_stack[sp];
        end
      end
      OPC_JP: pc_reg = {4'h0, nnn};
      OPC_CALL: begin
        if (sp < STACK_SLOTS) begin
          ret_stack[sp] = pc_reg;
          sp++;
        end
        pc_reg = {4'h0, nnn};
      end
      OPC_SE:   if (vreg[x] == nn) pc_reg = pc_reg + 16'd2;
      OPC_SNE:  if (vreg[x] != nn) pc_reg = pc_reg + 16'd2;
      OPC_SER:  if (vreg[x] == vreg[y]) pc_reg = pc_reg + 16'd2;
      OPC_LD:   vreg[x] = nn;
      OPC_ADD:  vreg[x] = vreg[x] + nn;
      OPC_ALU: begin
        case (alu_t'(n))
          ALU_MOV: vreg[x] = vreg[y];
          ALU_OR:  begin vreg[x] = vreg[x] | vreg[y]; vreg[15] = 8'h0; end
          ALU_AND: begin vreg[x] = vreg[x] & vreg[y]; vreg[15] = 8'h0; end
          ALU_XOR: begin vreg[x] = vreg[x] ^ vreg[y]; vreg[15] = 8'h0; end
          ALU_ADD: begin
            sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
            vreg[x] = sum[7:0];
            vreg[15] = {7'h0, sum[8]};
          end
          ALU_SUB: begin
            f = {7'h0, vreg[x] >= vreg[y]};
            vreg[x] = vreg[x] - vreg[y];
            vreg[15] = f;
          end
          ALU_SHR: begin
            f = {7'h0, vreg[x][0]};
            vreg[x] = vreg[x] >> 1;
            vreg[15] = f;
          end
          ALU_SUBN: begin
            f = {7'h0, vreg[y] >= vreg[x]};
            vreg[x] = vreg[y] - vreg[x];
            vreg[15] = f;
          end
          ALU_SHL: begin
            f = {7'h0, vreg[x][7]};
            vreg[x] = vreg[x] << 1;
            vreg[15] = f;
          end
          default: ;
        endcase
      end
      OPC_SNER: if (vreg[x] != vreg[y]) pc_reg = pc_reg + 16'd2;
      OPC_LDI:  idx_reg = {4'h0, nnn};
      OPC_JPV:  pc_reg = {4'h0, nnn} + {8'h0, vreg[0]};
      OPC_RND:  vreg[x] = rnd & nn;
      OPC_DRW: begin
        xpos = vreg[x] % 64;
        ypos = vreg[y] % 32;
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
          if (ypos + r >= 32) break;
          bits = {mem[12'(idx_reg + 16'(r))], 56'h0} >> xpos;
          if ((screen[ypos + r] & bits) != 64'h0) hit = 1'b1;
          screen[ypos + r] = screen[ypos + r] ^ bits;
        end
        vreg[15] = {7'h0, hit};
        redraw_flag = 1'b1;
      end
      OPC_KEY: begin
        if (nn == FN_SKP) begin
          if (vreg[x] < 16 && keys[vreg[x][3:0]]) pc_reg = pc_reg + 16'd2;
        end else if (nn == FN_SKNP) begin
          if (vreg[x] >= 16 || !keys[vreg[x][3:0]]) pc_reg = pc_reg + 16'd2;
        end
      end
      default: begin
        case (nn)
          FN_LD_DT:  vreg[x] = delay_cnt;
          FN_WAIT:   begin key_waiting = 1'b1; key_dest = x; end
          FN_SET_DT: delay_cnt = vreg[x];
          FN_SET_ST: sound_cnt = vreg[x];
          FN_ADD_I:  idx_reg = idx_reg + {8'h0, vreg[x]};
          FN_FONT:   idx_reg = FONT_BASE + 16'(vreg[x][3:0]) * 16'd5;
          FN_BCD: begin
            if (int'(idx_reg) + 2 < 4096) begin
              mem[idx_reg[11:0]] = vreg[x] / 100;
              mem[idx_reg[11:0] + 12'd1] = (vreg[x] / 10) % 10;
              mem[idx_reg[11:0] + 12'd2] = vreg[x] % 10;
            end
          end
          FN_STORE:
            for (int i = 0; i <= x && int'(idx_reg) + i < 4096; i++)
              mem[int'(idx_reg) + i] = vreg[i];
          FN_LOAD:
            for (int i = 0; i <= x && int'(idx_reg) + i < 4096; i++)
              vreg[i] = mem[int'(idx_reg) + i];
          default: ;
        endcase
      end
    endcase
  endfunction

  function automatic status_t machine_step(input word_t w);
    status_t s;
    s.pixels = 64'h0;
    case (w.kind)
      KIND_RESET: machine_reset();
      KIND_LOAD:  mem[w.addr] = w.data;
      KIND_START: running = 1'b1;
      KIND_EXEC:  machine_execute(w.rnd);
      KIND_KEY:   keys[w.key] = w.down;
      KIND_ROW:   s.pixels = screen[w.row];
      default: ;
    endcase
    s.redraw = redraw_flag;
    if (w.kind == KIND_TICK) begin
      if (delay_cnt > 0) delay_cnt = delay_cnt - 8'd1;
      if (sound_cnt > 0) sound_cnt = sound_cnt - 8'd1;
      redraw_flag = 1'b0;
    end
    s.pc = pc_reg;
    s.run = running;
    s.wait_k = key_waiting;
    s.sound = sound_cnt != 0;
    return s;
  endfunction

  // stimulus helpers
  task automatic queue_word(input logic [2:0] k, input logic [11:0] a = 12'h0,
                            input logic [7:0] d = 8'h0, input logic [3:0] kn = 4'h0,
                            input logic dn = 1'b0, input logic [4:0] r = 5'h0);
    word_t w;
    w.drain = 1'b0;
    w.kind = k;
    w.addr = a;
    w.data = d;
    w.key = kn;
    w.down = dn;
    w.row = r;
    w.rnd = 8'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic queue_op(input logic [11:0] a, input logic [15:0] op);
    queue_word(KIND_LOAD, a, op[15:8]);
    queue_word(KIND_LOAD, a + 12'd1, op[7:0]);
  endtask

  function automatic logic [11:0] pick_target();
    case ($urandom_range(0, 9))
      0: return 12'($urandom);
      1: return 12'hFFE + 12'($urandom_range(0, 1));
      default: return PROG_BASE[11:0] + 12'($urandom_range(0, 31) * 2);
    endcase
  endfunction

  function automatic logic [15:0] random_op();
    logic [3:0] c, x, y, n;
    logic [7:0] nn;
    c = 4'($urandom);
    x = 4'($urandom);
    y = 4'($urandom);
    n = 4'($urandom);
    nn = 8'($urandom);
    case (opclass_t'(c))
      OPC_SYS: case ($urandom_range(0, 3))
        0: return OP_CLS;
        1, 2: return OP_RET;
        default: return {c, x, y, n};
      endcase
      OPC_JP, OPC_CALL, OPC_JPV: return {c, pick_target()};
      OPC_LDI: return {c, ($urandom_range(0, 3) == 0) ? 12'hFFE : 12'($urandom)};
      OPC_KEY: return {c, x, ($urandom_range(0, 4) == 0) ? nn
                                 : ($urandom_range(0, 1) ? FN_SKP : FN_SKNP)};
      OPC_MISC: case ($urandom_range(0, 10))
        0: return {c, x, FN_LD_DT};
        1: return {c, x, FN_WAIT};
        2: return {c, x, FN_SET_DT};
        3: return {c, x, FN_SET_ST};
        4: return {c, x, FN_ADD_I};
        5: return {c, x, FN_FONT};
        6: return {c, x, FN_BCD};
        7: return {c, x, FN_STORE};
        8: return {c, x, FN_LOAD};
        default: return {c, x, nn};
      endcase
      default: return {c, x, y, n};
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    word_t hold;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    kind = 3'h0;
    load_address = 12'h0;
    load_data = 8'h0;
    key_number = 4'h0;
    key_down = 1'b0;
    row_select = 5'h0;
    random_byte = 8'h0;
    stim_done = 1'b0;
    machine_reset();
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed opening
    queue_word(KIND_ROW, 12'h0, 8'h0, 4'h0, 1'b0, 5'd0);
    queue_word(KIND_ROW, 12'hFFF, 8'hFF, 4'hF, 1'b1, 5'd31);
    queue_word(KIND_TICK);
    queue_word(KIND_EXEC);
    queue_word(KIND_KEY, 12'h0, 8'h0, 4'hF, 1'b1);
    queue_word(KIND_LOAD, 12'hFFF, 8'hFF);
    queue_word(KIND_LOAD, 12'h000, 8'h00);
    queue_op(12'h200, 16'h60FF);
    queue_op(12'h202, 16'h800E);
    queue_op(12'h204, 16'hF10A);
    queue_op(12'h206, 16'hD01F);
    queue_op(12'h208, 16'hF018);
    queue_word(KIND_START);
    repeat (6) queue_word(KIND_EXEC);
    queue_word(KIND_ROW, 12'h0, 8'h0, 4'h0, 1'b0, 5'd0);
    queue_word(KIND_TICK);
    queue_word(KIND_KEY, 12'h0, 8'h0, 4'hF, 1'b0);

    // random programs
    for (int seg = 0; pending_words.size() + words_taken < ITEM_GOAL; seg++) begin
      if (seg % 5 == 4) queue_word(KIND_RESET);
      if (seg == 6) begin
        hold.drain = 1'b1;
        pending_words.push_back(hold);
      end
      for (int i = 0; i < 16; i++)
        queue_op(PROG_BASE[11:0] + 12'(2 * $urandom_range(0, 31)), random_op());
      if ($urandom_range(0, 3) == 0) queue_op(12'hFFC + 12'(2 * $urandom_range(0, 1)),
                                              random_op());
      queue_word(KIND_START);
      for (int i = 0; i < 30; i++) begin
        case ($urandom_range(0, 11))
          0: queue_word(KIND_TICK);
          1: queue_word(KIND_KEY, 12'h0, 8'h0, 4'($urandom), 1'($urandom));
          2: queue_word(KIND_ROW, 12'h0, 8'h0, 4'h0, 1'b0, 5'($urandom));
          3: queue_word(3'($urandom_range(1, 6)), 12'($urandom), 8'($urandom),
                        4'($urandom), 1'($urandom), 5'($urandom));
          default: queue_word(KIND_EXEC);
        endcase
      end
    end
    stim_done = 1'b1;
  end

  // input side
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      word_t w;
      w.drain = 1'b0;
      w.kind = kind;
      w.addr = load_address;
      w.data = load_data;
      w.key = key_number;
      w.down = key_down;
      w.row = row_select;
      w.rnd = random_byte;
      expected_status.push_back(machine_step(w));
      words_taken <= words_taken + 1;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      word_t w;
      if (draining) begin
        in_valid <= 1'b0;
        if (expected_status.size() == 0) draining <= 1'b0;
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (words_taken < CALM_AFTER && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        in_gap <= $urandom_range(0, 5);
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        if (w.drain) begin
          in_valid <= 1'b0;
          draining <= 1'b1;
        end else begin
          in_valid <= 1'b1;
          kind <= w.kind;
          load_address <= w.addr;
          load_data <= w.data;
          key_number <= w.key;
          key_down <= w.down;
          row_select <= w.row;
          random_byte <= w.rnd;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  int stall_left;
  bit stalled_once;
  always @(negedge clk) begin
    if (!rst) begin
      if (!stalled_once && words_taken >= 400) begin
        stalled_once <= 1'b1;
        stall_left <= 400;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (words_taken < CALM_AFTER && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      status_t e;
      results_seen <= results_seen + 1;
      if (expected_status.size() == 0) begin
        $error("result with no word pending: pc %h", program_counter);
        fail_count++;
      end else begin
        e = expected_status.pop_front();
        if (program_counter !== e.pc) begin
          $error("program_counter: expected %h, actual %h", e.pc, program_counter);
          fail_count++;
        end
        if (is_running !== e.run) begin
          $error("is_running: expected %b, actual %b", e.run, is_running);
          fail_count++;
        end
        if (awaiting_key !== e.wait_k) begin
          $error("awaiting_key: expected %b, actual %b", e.wait_k, awaiting_key);
          fail_count++;
        end
        if (redraw_needed !== e.redraw) begin
          $error("redraw_needed: expected %b, actual %b", e.redraw, redraw_needed);
          fail_count++;
        end
        if (sound_on !== e.sound) begin
          $error("sound_on: expected %b, actual %b", e.sound, sound_on);
          fail_count++;
        end
        if (row_pixels !== e.pixels) begin
          $error("row_pixels: expected %h, actual %h", e.pixels, row_pixels);
          fail_count++;
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_words.size() == 0 && !in_valid && !draining);
    wait (expected_status.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[chip8_interpreter_core.f]
+incdir+design
design/chip8_pkg.sv
design/chip8_ram.sv
design/chip8_interpreter_core.sv
tb/chip8_interpreter_core_test.sv
